>>> src/srt_pkg.sv
// ----------------------------------------------------------------------------
// srt_pkg: shared types and codes for the sorted route table
// Operation and status codes, the entry record layout.
// ----------------------------------------------------------------------------
package srt_pkg;

   localparam logic [2:0] OP_FIND   = 3'd0;
   localparam logic [2:0] OP_INSERT = 3'd1;
   localparam logic [2:0] OP_REMOVE = 3'd2;
   localparam logic [2:0] OP_FINDN  = 3'd3;
   localparam logic [2:0] OP_READ   = 3'd4;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_DUP      = 3'd1;
   localparam logic [2:0] ST_FULL     = 3'd2;
   localparam logic [2:0] ST_NOTFOUND = 3'd3;
   localparam logic [2:0] ST_RANGE    = 3'd4;

   typedef struct packed {
      logic [63:0] name;
      logic [3:0]  name_len;
      logic [63:0] src_high;
      logic [63:0] src_low;
      logic [7:0]  src_len;
      logic [15:0] metric;
      logic [31:0] iface;
      logic [7:0]  proto;
   } entry_type;

endpackage

>>> src/srt_cmp.sv
// ----------------------------------------------------------------------------
// srt_cmp: key compare
// Three-way compare of a search key against one stored entry.
// ----------------------------------------------------------------------------
module srt_cmp
   import srt_pkg::*;
(
   input  entry_type key,
   input  entry_type ent,
   input  logic      name_only,
   output logic      eq,
   output logic      lt
);
   always_comb begin
      eq = 1'b0;
      lt = 1'b0;
      if (key.name_len != ent.name_len) begin
         lt = key.name_len < ent.name_len;
      end else if (key.name != ent.name) begin
         lt = key.name < ent.name;
      end else if (name_only || (key.src_len == 8'd0 && ent.src_len == 8'd0)) begin
         eq = 1'b1;
      end else if (key.src_len != ent.src_len) begin
         lt = key.src_len < ent.src_len;
      end else if (key.src_high != ent.src_high) begin
         lt = key.src_high < ent.src_high;
      end else if (key.src_low != ent.src_low) begin
         lt = key.src_low < ent.src_low;
      end else begin
         eq = 1'b1;
      end
   end
endmodule

>>> src/sorted_route_table_top.sv
// ----------------------------------------------------------------------------
// sorted_route_table_top: sorted route table
// Table of routes kept in key order in one synchronous memory.
// ----------------------------------------------------------------------------
// Usage: one request on the req_ channel (valid/stall) yields one response on
// the rsp_ channel. A request is taken only while no other is in progress.
// Lookups run a binary search over the memory's one read port; each probe
// reads an entry (S_PROBE), then compares it (S_CMP). Insert adds one move
// per shifted entry (read, then write), remove likewise, so an insert or
// remove at the bottom of the table moves every entry above it. A read
// goes through S_FETCH, then S_OUT. The memory's one read port paces each step.
// The response stays in an output register while rsp_stall is high; one more
// request can be taken and worked off meanwhile, and its result then waits
// with req_stall high until the output register frees. Reset empties the
// table (count to zero) at once; memory contents are not cleared and entries
// above the count are never read.
// ----------------------------------------------------------------------------
module sorted_route_table_top
   import srt_pkg::*;
#(
   parameter int CAPACITY   = 64,
   parameter int NAME_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_op,
   input  logic [3:0]  req_name_len,
   input  logic [63:0] req_name_bytes,
   input  logic [7:0]  req_src_len,
   input  logic [63:0] req_src_high,
   input  logic [63:0] req_src_low,
   input  logic [15:0] req_route_metric,
   input  logic [31:0] req_iface_number,
   input  logic [7:0]  req_origin_proto,
   input  logic [5:0]  req_slot_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [5:0]  rsp_hit_index,
   output logic [3:0]  rsp_out_name_len,
   output logic [63:0] rsp_out_name_bytes,
   output logic [7:0]  rsp_out_src_len,
   output logic [63:0] rsp_out_src_high,
   output logic [63:0] rsp_out_src_low,
   output logic [15:0] rsp_out_metric,
   output logic [31:0] rsp_out_iface,
   output logic [7:0]  rsp_out_proto,
   output logic [6:0]  rsp_entry_total
);
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int SW = CW + 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PROBE = 3'd1;
   localparam logic [2:0] S_CMP   = 3'd2;
   localparam logic [2:0] S_MVRD  = 3'd3;
   localparam logic [2:0] S_MVWR  = 3'd4;
   localparam logic [2:0] S_FETCH = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;
   localparam logic [2:0] S_OUT   = 3'd7;

   entry_type mem [CAPACITY];
   entry_type rd_ff;
   logic [AW-1:0] raddr;
   logic          we;
   logic [AW-1:0] waddr;
   entry_type     wdata;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_ff <= mem[raddr];
   end

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [2:0]    op_ff, op_in;
   entry_type     key_ff, key_in;
   logic signed [SW-1:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [2:0]    st_ff, st_in;
   logic [AW-1:0] hit_ff, hit_in;
   entry_type     res_ff, res_in;
   logic          rv_ff, rv_in;

   logic signed [SW:0] midw;
   logic [AW-1:0] mid;
   logic eq, lt;
   logic [63:0] nmask;
   logic [3:0]  neff;

   assign midw = ($signed({lo_ff[SW-1], lo_ff}) + $signed({hi_ff[SW-1], hi_ff})) >>> 1;
   assign mid  = midw[AW-1:0];

   srt_cmp u_cmp (
      .key(key_ff), .ent(rd_ff), .name_only(op_ff == OP_FINDN), .eq(eq), .lt(lt)
   );

   always_comb begin
      neff = (req_name_len > 4'(NAME_BYTES)) ? 4'(NAME_BYTES) : req_name_len;
      nmask = (neff == 4'd0) ? 64'd0 : ~(64'hFFFF_FFFF_FFFF_FFFF >> (7'(neff) * 7'd8));
   end

   always_comb begin
      state_in = state_ff; count_in = count_ff; op_in = op_ff; key_in = key_ff;
      lo_in = lo_ff; hi_in = hi_ff; ptr_in = ptr_ff;
      st_in = st_ff; hit_in = hit_ff; res_in = res_ff; rv_in = rv_ff;
      raddr = mid; we = 1'b0; waddr = ptr_ff[AW-1:0]; wdata = rd_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in = req_op;
               key_in.name     = req_name_bytes & nmask;
               key_in.name_len = req_name_len;
               key_in.src_high = req_src_high;
               key_in.src_low  = req_src_low;
               key_in.src_len  = req_src_len;
               key_in.metric   = req_route_metric;
               key_in.iface    = req_iface_number;
               key_in.proto    = req_origin_proto;
               lo_in = '0;
               hi_in = $signed({1'b0, count_ff}) - SW'(1);
               st_in = ST_OK; hit_in = '0; res_in = '0;
               if (req_op == OP_FIND || req_op == OP_FINDN || req_op == OP_INSERT) begin
                  state_in = S_PROBE;
               end else if ((req_op == OP_REMOVE || req_op == OP_READ) &&
                            {1'b0, req_slot_index} < 7'(count_ff)) begin
                  hit_in = req_slot_index[AW-1:0];
                  state_in = S_FETCH;
               end else begin
                  st_in = ST_RANGE;
                  state_in = S_DONE;
               end
            end
         end
         S_PROBE: begin
            if (lo_ff > hi_ff) begin
               if (op_ff != OP_INSERT) begin
                  st_in = ST_NOTFOUND;
                  state_in = S_DONE;
               end else if (count_ff >= CW'(CAPACITY)) begin
                  st_in = ST_FULL;
                  state_in = S_DONE;
               end else begin
                  hit_in = lo_ff[AW-1:0];
                  ptr_in = count_ff;
                  state_in = S_MVRD;
               end
            end else begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (eq) begin
               hit_in = mid;
               res_in = rd_ff;
               st_in = (op_ff == OP_INSERT) ? ST_DUP : ST_OK;
               state_in = S_DONE;
            end else if (lt) begin
               hi_in = $signed({1'b0, mid}) - SW'(1);
               state_in = S_PROBE;
            end else begin
               lo_in = $signed({1'b0, mid}) + SW'(1);
               state_in = S_PROBE;
            end
         end
         S_FETCH: begin
            raddr = hit_ff;
            state_in = S_OUT;
         end
         S_OUT: begin
            // entry data for remove/read is now in rd_ff
            res_in = rd_ff;
            if (op_ff == OP_REMOVE) begin
               ptr_in = CW'(hit_ff);
               state_in = S_MVRD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_MVRD: begin
            if (op_ff == OP_INSERT) begin
               if (ptr_ff == CW'(hit_ff)) begin
                  we = 1'b1; waddr = hit_ff; wdata = key_ff;
                  res_in = key_ff;
                  count_in = count_ff + CW'(1);
                  state_in = S_DONE;
               end else begin
                  raddr = AW'(ptr_ff - CW'(1));
                  state_in = S_MVWR;
               end
            end else begin
               if (ptr_ff + CW'(1) >= count_ff) begin
                  count_in = count_ff - CW'(1);
                  state_in = S_DONE;
               end else begin
                  raddr = AW'(ptr_ff + CW'(1));
                  state_in = S_MVWR;
               end
            end
         end
         S_MVWR: begin
            we = 1'b1; waddr = ptr_ff[AW-1:0]; wdata = rd_ff;
            ptr_in = (op_ff == OP_INSERT) ? ptr_ff - CW'(1) : ptr_ff + CW'(1);
            state_in = S_MVRD;
         end
         S_DONE: begin
            if (!rv_ff || !rsp_stall) begin
               rv_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (rv_ff && !rsp_stall && state_ff != S_DONE) begin
         rv_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rv_ff    <= rv_in;
      end
      op_ff <= op_in; key_ff <= key_in;
      lo_ff <= lo_in; hi_ff <= hi_in; ptr_ff <= ptr_in;
      st_ff <= st_in; hit_ff <= hit_in; res_ff <= res_in;
   end

   // response registers, loaded when the result is handed over
   logic [2:0]  o_st_ff;
   logic [5:0]  o_hit_ff;
   entry_type   o_ent_ff;
   logic [6:0]  o_tot_ff;
   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && (!rv_ff || !rsp_stall)) begin
         o_st_ff  <= st_ff;
         o_hit_ff <= 6'(hit_ff);
         o_ent_ff <= res_ff;
         o_tot_ff <= 7'(count_ff);
      end
   end

   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = rv_ff;
   assign rsp_status         = o_st_ff;
   assign rsp_hit_index      = o_hit_ff;
   assign rsp_out_name_len   = o_ent_ff.name_len;
   assign rsp_out_name_bytes = o_ent_ff.name;
   assign rsp_out_src_len    = o_ent_ff.src_len;
   assign rsp_out_src_high   = o_ent_ff.src_high;
   assign rsp_out_src_low    = o_ent_ff.src_low;
   assign rsp_out_metric     = o_ent_ff.metric;
   assign rsp_out_iface      = o_ent_ff.iface;
   assign rsp_out_proto      = o_ent_ff.proto;
   assign rsp_entry_total    = o_tot_ff;
endmodule
